FILE: rtl/scan_voxel_dedup_filter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scan voxel de-duplication filter.
// ---------------------------------------------------------------------------
`ifndef SCAN_VOXEL_DEDUP_FILTER_ASSERT_SVH
`define SCAN_VOXEL_DEDUP_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SVD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define SVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/svd_pkg.sv
// ---------------------------------------------------------------------------
// svd_pkg
// Types, constants and tables shared by the voxel de-duplication filter.
// ---------------------------------------------------------------------------
`default_nettype none

package svd_pkg;

    // Default parameter values.
    localparam int MAX_POINTS_DEF = 1024;
    localparam int RANGE_BITS_DEF = 16;

    // Field widths.
    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int CELL_W    = 17;
    localparam int KEY_W     = 2 * CELL_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 2'd2;

    // CORDIC constants: start gain in Q16, unit value and quarter turn.
    localparam logic signed [19:0] CORDIC_GAIN  = 20'sd39797;
    localparam logic signed [19:0] ONE_Q16      = 20'sd65536;
    localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;
    localparam logic [16:0]        CELL_LIM     = 17'd65535;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MUL,
        S_PRE,
        S_DIV,
        S_FIN,
        S_SRCH,
        S_CMP,
        S_UPD,
        S_DONE
    } t_state;

    // Arctangent table in binary-angle units.
    function automatic logic signed [17:0] atan_lut(input logic [3:0] idx);
        logic signed [17:0] v;
        case (idx)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            4'd14:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/svd_in_if.sv
// ---------------------------------------------------------------------------
// svd_in_if
// Input channel: one range sample per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface svd_in_if;
    import svd_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_in;
    logic               first_in_scan;

    modport source (output valid, range_in, first_in_scan, input ready);
    modport sink   (input valid, range_in, first_in_scan, output ready);
endinterface

`default_nettype wire

FILE: rtl/svd_out_if.sv
// ---------------------------------------------------------------------------
// svd_out_if
// Output channel: one filtered sample per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface svd_out_if;
    import svd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [RANGE_W-1:0]       range_out;
    logic                     duplicate;
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_y;
    logic                     capacity_exceeded;

    modport source (output valid, range_out, duplicate, cell_x, cell_y,
                    capacity_exceeded, input ready);
    modport sink   (input valid, range_out, duplicate, cell_x, cell_y,
                    capacity_exceeded, output ready);
endinterface

`default_nettype wire

FILE: rtl/svd_cfg_if.sv
// ---------------------------------------------------------------------------
// svd_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface svd_cfg_if;
    import svd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/svd_ram.sv
// ---------------------------------------------------------------------------
// svd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module svd_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

FILE: rtl/scan_voxel_dedup_filter.sv
// A result is registered after its sample is accepted, through these steps: the CORDIC
// rotation, then per axis a multiply, a prepare, a restoring divide and a finish state,
// then a search with a compare per stored cell, an update and a done state.
// A match ends the search early; a sample over capacity skips the search.
// A new sample is taken only once the last has left the done state, which waits for a free output.
// Reset is synchronous and active low; a fill count marks the valid seen-cell entries.
// ---------------------------------------------------------------------------
// scan_voxel_dedup_filter
// Laser-scan 2-D voxel grid filter: CORDIC sin/cos, grid cell by division,
// and a linear search of the cells already seen in this scan.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_voxel_dedup_filter #(
    parameter int MAX_POINTS = svd_pkg::MAX_POINTS_DEF,
    parameter int RANGE_BITS = svd_pkg::RANGE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    svd_cfg_if.sink    i_cfg,
    svd_in_if.sink     i_in,
    svd_out_if.source  o_out
);
    import svd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int RB     = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [RANGE_W-1:0] RMASK = RANGE_W'((33'd1 << RB) - 33'd1);

    t_state r_state, n_state;

    // Configuration and scan state.
    logic [ANGLE_W-1:0]  r_angle_start, r_angle_step, r_grid, r_angle;
    logic [CNT_W-1:0]    r_count, r_index, r_k;

    // Working registers.
    logic [RANGE_W-1:0]       r_rng;
    logic                     r_fold, r_axis, r_neg, r_dup, r_cap;
    logic [4:0]               r_it;
    logic signed [19:0]       r_cx, r_cy;
    logic signed [17:0]       r_z;
    logic signed [34:0]       r_prod;
    logic [16:0]              r_dnd, r_rem, r_quo;
    logic signed [CELL_W-1:0] r_cell_x, r_cell_y;

    // Output register.
    logic                     r_ov, r_odup, r_ocap;
    logic [RANGE_W-1:0]       r_orng;
    logic signed [CELL_W-1:0] r_ocx, r_ocy;

    logic [KEY_W-1:0] w_key, w_rdata;
    logic             w_out_free;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_key       = {r_cell_y, r_cell_x};

    // Seen-cell store.
    svd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_POINTS)) u_seen (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPD && !r_cap && !r_dup),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (w_key),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Angle folding for the incoming sample.
    logic [ANGLE_W-1:0] w_ang;
    logic signed [15:0] w_sang;
    logic               w_fold;
    always_comb begin
        w_ang  = i_in.first_in_scan ? r_angle_start : r_angle;
        w_sang = $signed(w_ang);
        w_fold = (w_sang > QUARTER_TURN) || (w_sang < -QUARTER_TURN);
    end

    // Shared CORDIC step.
    logic signed [19:0] w_dx, w_dy, w_xc, w_yc;
    logic signed [17:0] w_at;
    always_comb begin
        w_dx = r_cy >>> r_it[3:0];
        w_dy = r_cx >>> r_it[3:0];
        w_at = atan_lut(r_it[3:0]);
        w_xc = (r_cx > ONE_Q16) ? ONE_Q16 : ((r_cx < -ONE_Q16) ? -ONE_Q16 : r_cx);
        w_yc = (r_cy > ONE_Q16) ? ONE_Q16 : ((r_cy < -ONE_Q16) ? -ONE_Q16 : r_cy);
    end

    // Shared multiplier and magnitude; the clamped, unfolded cos or sin feeds it.
    logic signed [19:0] w_cs;
    logic signed [34:0] w_prod;
    logic [33:0]        w_mag;
    always_comb begin
        w_cs = r_axis ? w_yc : w_xc;
        if (r_fold) begin
            w_cs = -w_cs;
        end
        w_prod = 35'(signed'({1'b0, r_rng})) * 35'(w_cs);
        w_mag  = r_prod[34] ? 34'(-r_prod) : r_prod[33:0];
    end

    // Shared restoring divider step and result rounding.
    logic [15:0] w_grid;
    logic [16:0] w_trial;
    logic        w_ge;
    logic [17:0] w_qc;
    logic [16:0] w_qs;
    always_comb begin
        w_grid  = (r_grid == '0) ? 16'd1 : r_grid;
        w_trial = {r_rem[15:0], r_dnd[16]};
        w_ge    = w_trial >= {1'b0, w_grid};
        w_qc    = {1'b0, r_quo} + 18'((!r_neg && r_rem != '0) ? 1 : 0);
        w_qs    = (w_qc > {1'b0, CELL_LIM}) ? CELL_LIM : w_qc[16:0];
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_CORDIC;
            S_CORDIC: if (r_it == 5'd15) n_state = S_MUL;
            S_MUL:    n_state = S_PRE;
            S_PRE:    n_state = S_DIV;
            S_DIV:    if (r_it == 5'd16) n_state = S_FIN;
            S_FIN:    n_state = r_axis ? (r_cap ? S_UPD : S_SRCH) : S_MUL;
            S_SRCH:   n_state = (r_k >= r_count) ? S_UPD : S_CMP;
            S_CMP:    n_state = (w_rdata == w_key) ? S_UPD : S_SRCH;
            S_UPD:    n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Configuration registers and scan control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_grid        <= 16'd1;
            r_angle       <= '0;
            r_count       <= '0;
            r_index       <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ANGLE_START: r_angle_start <= i_cfg.data;
                    CFG_ANGLE_STEP:  r_angle_step  <= i_cfg.data;
                    CFG_GRID_SIZE:   r_grid        <= i_cfg.data;
                    default:         ;
                endcase
            end
            if (r_state == S_IDLE && i_in.valid) begin
                r_angle <= w_ang + r_angle_step;
                if (i_in.first_in_scan) begin
                    r_count <= '0;
                    r_index <= '0;
                end
            end
            if (r_state == S_UPD && !r_cap) begin
                r_index <= r_index + 1'b1;
                if (!r_dup) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rng  <= i_in.range_in & RMASK;
                r_fold <= w_fold;
                r_cx   <= CORDIC_GAIN;
                r_cy   <= '0;
                r_z    <= 18'(w_fold ? $signed(w_ang + 16'h8000) : w_sang);
                r_it   <= '0;
                r_axis <= 1'b0;
                r_dup  <= 1'b0;
                r_k    <= '0;
                r_cap  <= !i_in.first_in_scan && (r_index >= CNT_MAX);
            end
            S_CORDIC: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_z  <= r_z - w_at;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_z  <= r_z + w_at;
                end
                r_it <= r_it + 1'b1;
            end
            S_MUL: begin
                r_prod <= w_prod;
            end
            S_PRE: begin
                // Ceil toward plus infinity for positive, truncate for negative.
                r_neg <= r_prod[34];
                r_dnd <= 17'(w_mag[33:16]) +
                         17'((!r_prod[34] && w_mag[15:0] != '0) ? 1 : 0);
                r_rem <= '0;
                r_quo <= '0;
                r_it  <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? (w_trial - {1'b0, w_grid}) : w_trial;
                r_quo <= {r_quo[15:0], w_ge};
                r_dnd <= {r_dnd[15:0], 1'b0};
                r_it  <= r_it + 1'b1;
            end
            S_FIN: begin
                if (r_axis) begin
                    r_cell_y <= r_neg ? -$signed(w_qs) : $signed(w_qs);
                end else begin
                    r_cell_x <= r_neg ? -$signed(w_qs) : $signed(w_qs);
                end
                r_axis <= 1'b1;
            end
            S_CMP: begin
                if (w_rdata == w_key) begin
                    r_dup <= 1'b1;
                end
                r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register: loaded when the result is done and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_orng <= r_dup ? '0 : r_rng;
            r_odup <= r_dup;
            r_ocap <= r_cap;
            r_ocx  <= r_cell_x;
            r_ocy  <= r_cell_y;
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.range_out         = r_orng;
    assign o_out.duplicate         = r_odup;
    assign o_out.cell_x            = r_ocx;
    assign o_out.cell_y            = r_ocy;
    assign o_out.capacity_exceeded = r_ocap;

    `include "scan_voxel_dedup_filter_assert.svh"

    // A duplicate always carries a zero range and is never over capacity.
    `SVD_ASSERT_IMPL(a_dup_zero, i_clk, i_rst_n, r_ov && r_odup, r_orng == '0 && !r_ocap)
    // The fill count never runs past the store depth or the sample index.
    `SVD_ASSERT_IMPL(a_count_lim, i_clk, i_rst_n, 1'b1, r_count <= r_index && r_index <= CNT_MAX)
    // An accepted sample holds off the input until it is finished.
    `SVD_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
endmodule

`default_nettype wire

FILE: tb/sv/scan_voxel_dedup_filter_test.sv
// ---------------------------------------------------------------------------
// scan_voxel_dedup_filter_test
// Self-checking bench for the scan voxel de-duplication filter. A directed
// table runs first, then random scans under several register settings.
// Every result is compared field by field against the table's expected value
// or an in-bench predictor of the sin/cos, grid cell and seen-cell logic.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_voxel_dedup_filter_test;
    import svd_pkg::*;

    localparam int SEEN_DEPTH = 1024;
    localparam int DRAIN_WAIT = 120;

    typedef struct packed {
        logic [RANGE_W-1:0]       rng;
        logic                     dup;
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic                     cap;
    } t_cell_result;

    typedef struct {
        logic [RANGE_W-1:0] rng;
        logic               first;
        bit                 typed;
        t_cell_result       want;
    } t_sample_row;

    logic i_clk;
    logic i_rst_n;

    svd_cfg_if cfg_ch ();
    svd_in_if  in_ch ();
    svd_out_if out_ch ();

    scan_voxel_dedup_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow registers and scan state of the predictor.
    logic [15:0]      shadow_start;
    logic [15:0]      shadow_step;
    logic [15:0]      shadow_grid;
    logic [15:0]      scan_angle;
    logic [KEY_W-1:0] seen_keys [SEEN_DEPTH];
    int               seen_fill;
    int               sample_pos;

    t_cell_result pending_cells[$];
    int           error_count;
    int           items_sent;
    int           results_seen;
    int           dups_seen;
    int           caps_seen;
    bit           quiet;
    bit           hold_request;

    int arctan_steps [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                              41, 20, 10, 5, 3, 1, 1, 0};

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none while quiet.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint div_up(input longint num, input longint den);
        if (num >= 0) return (num + den - 1) / den;
        return -((-num) / den);
    endfunction

    // 16-step CORDIC rotation, with a half-turn fold outside +-quarter turn.
    task automatic rotate_unit(input logic [15:0] ang, output longint c, output longint s);
        int          a;
        int          z;
        bit          flip;
        logic [15:0] folded;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        a = $signed(ang);
        flip = 1'b0;
        x = 39797;
        y = 0;
        if (a > 16384 || a < -16384) begin
            folded = ang + 16'h8000;
            a = $signed(folded);
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_steps[i];
            end else begin
                x += dx; y -= dy; z += arctan_steps[i];
            end
        end
        x = clamp_to(x, -65536, 65536);
        y = clamp_to(y, -65536, 65536);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Predict the filtered sample for one accepted transaction.
    task automatic predict_cell(input logic [15:0] rng, input logic first,
                                output t_cell_result res);
        longint           c;
        longint           s;
        longint           den;
        longint           cx;
        longint           cy;
        logic [KEY_W-1:0] key;
        bit               found;
        if (first) begin
            seen_fill = 0;
            sample_pos = 0;
            scan_angle = shadow_start;
        end
        rotate_unit(scan_angle, c, s);
        den = longint'((shadow_grid == 0) ? 16'd1 : shadow_grid) * 65536;
        cx = clamp_to(div_up(longint'(rng) * c, den), -65535, 65535);
        cy = clamp_to(div_up(longint'(rng) * s, den), -65535, 65535);
        key = {cy[CELL_W-1:0], cx[CELL_W-1:0]};
        res.rng = rng;
        res.dup = 1'b0;
        res.cap = 1'b0;
        res.cx = cx[CELL_W-1:0];
        res.cy = cy[CELL_W-1:0];
        if (sample_pos >= SEEN_DEPTH) begin
            res.cap = 1'b1;
        end else begin
            found = 1'b0;
            for (int k = 0; k < seen_fill; k++) begin
                if (seen_keys[k] == key) begin
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                res.dup = 1'b1;
                res.rng = '0;
            end else if (seen_fill < SEEN_DEPTH) begin
                seen_keys[seen_fill] = key;
                seen_fill++;
            end
            sample_pos++;
        end
        scan_angle = scan_angle + shadow_step;
    endtask

    // Offer one sample and record its expected result once it is taken.
    task automatic send_sample(input logic [15:0] rng, input logic first,
                               input bit typed, input t_cell_result want);
        int           gap;
        t_cell_result res;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.range_in <= rng;
        in_ch.first_in_scan <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_cell(rng, first, res);
        pending_cells = {pending_cells, (typed ? want : res)};
        items_sent++;
    endtask

    // Drain the pipeline, then write all three registers.
    task automatic program_regs(input logic [15:0] start, input logic [15:0] step,
                                input logic [15:0] grid);
        logic [15:0] vals [3];
        logic [CFG_IDX_W-1:0] idx [3];
        vals = '{start, step, grid};
        idx = '{CFG_ANGLE_START, CFG_ANGLE_STEP, CFG_GRID_SIZE};
        in_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data <= vals[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        shadow_start = start;
        shadow_step = step;
        shadow_grid = grid;
    endtask

    // One scan of random content; ranges are kept near the grid size so
    // that cells repeat, with full-scale and noise samples mixed in.
    task automatic send_scan(input int len, input bit broken);
        logic [15:0]  rng;
        logic         first;
        int           pick;
        t_cell_result none;
        none = '0;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                rng = 16'($urandom_range(0, (shadow_grid < 16'd8192) ?
                                            shadow_grid * 8 + 3 : 65535));
            else if (pick < 8)
                rng = 16'($urandom);
            else
                rng = (pick == 8) ? 16'hFFFF : 16'h0000;
            first = (i == 0) || (broken && ($urandom_range(0, 15) == 0));
            send_sample(rng, first, 1'b0, none);
        end
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Receiver: compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual range %0d",
                         $time, out_ch.range_out);
                error_count++;
            end else begin
                check_field("range_out", pending_cells[0].rng, out_ch.range_out);
                check_field("duplicate", pending_cells[0].dup, out_ch.duplicate);
                check_field("cell_x", pending_cells[0].cx, out_ch.cell_x);
                check_field("cell_y", pending_cells[0].cy, out_ch.cell_y);
                check_field("capacity_exceeded", pending_cells[0].cap,
                            out_ch.capacity_exceeded);
                void'(pending_cells.pop_front());
            end
            results_seen++;
            if (out_ch.duplicate) dups_seen++;
            if (out_ch.capacity_exceeded) caps_seen++;
        end
    end

    // Receiver stalls, including one long hold-off on request.
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = hold_request ? 400 : pick_gap();
            hold_request = 1'b0;
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Directed table, then random phases.
    initial begin
        t_sample_row rows [14];
        t_cell_result none;
        int budget;
        int phase;
        none = '0;
        rows = '{
            '{16'h0000, 1'b0, 1'b1, '{16'd0, 1'b0, 17'sd0, 17'sd0, 1'b0}},
            '{16'h0000, 1'b0, 1'b1, '{16'd0, 1'b1, 17'sd0, 17'sd0, 1'b0}},
            '{16'hFFFF, 1'b0, 1'b0, none},
            '{16'h0001, 1'b0, 1'b0, none},
            '{16'hFFFF, 1'b0, 1'b0, none},
            '{16'h5555, 1'b1, 1'b0, none},
            '{16'hAAAA, 1'b0, 1'b0, none},
            '{16'h0000, 1'b1, 1'b1, '{16'd0, 1'b0, 17'sd0, 17'sd0, 1'b0}},
            '{16'h0000, 1'b0, 1'b1, '{16'd0, 1'b1, 17'sd0, 17'sd0, 1'b0}},
            '{16'hFFFF, 1'b1, 1'b0, none},
            '{16'h8000, 1'b0, 1'b0, none},
            '{16'h00FF, 1'b0, 1'b0, none},
            '{16'h7FFF, 1'b0, 1'b0, none},
            '{16'hFFFE, 1'b0, 1'b0, none}
        };

        i_rst_n <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_ANGLE_START;
        cfg_ch.data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.range_in <= '0;
        in_ch.first_in_scan <= 1'b0;
        shadow_start = 16'd0;
        shadow_step = 16'd0;
        shadow_grid = 16'd1;
        scan_angle = 16'd0;
        seen_fill = 0;
        sample_pos = 0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        dups_seen = 0;
        caps_seen = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_sample(rows[i].rng, rows[i].first, rows[i].typed, rows[i].want);

        // Register extremes first, including a zero grid size.
        budget = items_sent + 880;
        phase = 0;
        while (items_sent < budget) begin
            case (phase)
                0: program_regs(16'h8000, 16'h7FFF, 16'd0);
                1: program_regs(16'h7FFF, 16'h8000, 16'hFFFF);
                2: program_regs(16'h4000, 16'h0100, 16'd100);
                3: program_regs(16'hC000, 16'hFC00, 16'd7);
                4: program_regs(16'h0000, 16'h0001, 16'd1);
                default: program_regs(16'($urandom), 16'($urandom),
                                      16'(($urandom_range(0, 3) == 0) ?
                                          $urandom : $urandom_range(1, 300)));
            endcase
            quiet = (phase % 3 == 2);
            for (int s = 0; s < 4; s++) begin
                if (phase == 2 && s == 1) hold_request = 1'b1;
                send_scan($urandom_range(3, 40), $urandom_range(0, 4) == 0);
            end
            phase++;
        end
        quiet = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d samples and %0d results over %0d register settings.",
                 items_sent, results_seen, phase + 1);
        $display("Duplicates flagged: %0d, samples past capacity: %0d.",
                 dups_seen, caps_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
